@@ rtl/core/ehbc_pkg.sv @@
// Shared types and constants for the EMA history bar chart.
// No dependencies; imported by every module of the block except ehbc_ram.
package ehbc_pkg;

    localparam int DEF_HISTORY_DEPTH = 64;

    localparam int SAMPLE_W    = 16;                 // Q12.4 rate sample
    localparam int AVG_W       = 20;                 // Q12.8 running average
    localparam int HEIGHT_W    = 6;                  // chart height / bar height
    localparam int COL_W       = 6;                  // column field
    localparam int NUM_W       = AVG_W + HEIGHT_W;   // bar divider numerator
    localparam int AVG_NUM_W   = AVG_W + 3;          // 4*avg + 16*sample
    localparam int DCNT_W      = 3;                  // divider step counter

    // A bar quotient never exceeds 63, so six steps suffice
    localparam logic [DCNT_W-1:0] BAR_STEPS = DCNT_W'(HEIGHT_W);

    // Average update divides by 5: multiply by ceil(2^25/5) and shift by 25,
    // exact for every numerator below 2^23
    localparam int                   AVG_RECIP_W = 23;
    localparam int                   AVG_SHIFT   = 25;
    localparam logic [AVG_RECIP_W-1:0] AVG_RECIP = AVG_RECIP_W'(6710887);

    localparam logic [AVG_W-1:0]    AVG_DIVISOR  = AVG_W'(5);
    localparam logic [AVG_W-1:0]    FLOOR_ONE    = AVG_W'(256);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(15);

    typedef enum logic [3:0] {
        S_IDLE,
        S_AVG,
        S_CHECK,
        S_SCAN,
        S_SCAN_END,
        S_BAR_RD,
        S_BAR_START,
        S_BAR_DIV,
        S_BAR_OUT
    } t_state;

endpackage

@@ rtl/core/ehbc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ehbc_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/ehbc_div.sv @@
// Restoring divider for the bar scaling, one quotient bit per cycle.
// Depends on ehbc_pkg.
module ehbc_div
    import ehbc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_W-1:0]    i_num,
    input  logic [AVG_W-1:0]    i_den,
    output logic                o_done,
    output logic [HEIGHT_W-1:0] o_quot
);

    logic [AVG_W-1:0]    r_rem, n_rem;
    logic [HEIGHT_W-1:0] r_sh, n_sh;
    logic [HEIGHT_W-1:0] r_q, n_q;
    logic [AVG_W-1:0]    r_den, n_den;
    logic [DCNT_W-1:0]   r_cnt, n_cnt;
    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [AVG_W:0]      trial;
    logic                ge;

    // One trial subtraction per cycle
    assign trial = {r_rem, r_sh[HEIGHT_W-1]};
    assign ge    = (trial >= {1'b0, r_den});

    always_comb begin
        n_rem  = r_rem;
        n_sh   = r_sh;
        n_q    = r_q;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            // partial remainder starts below the divisor: value <= max
            n_den  = i_den;
            n_q    = '0;
            n_busy = 1'b1;
            n_rem  = i_num[NUM_W-1:HEIGHT_W];
            n_sh   = i_num[HEIGHT_W-1:0];
            n_cnt  = BAR_STEPS;
        end else if (r_busy) begin
            n_rem = ge ? AVG_W'(trial - {1'b0, r_den}) : trial[AVG_W-1:0];
            n_sh  = {r_sh[HEIGHT_W-2:0], 1'b0};
            n_q   = {r_q[HEIGHT_W-2:0], ge};
            n_cnt = r_cnt - DCNT_W'(1);
            if (r_cnt == DCNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_sh  <= n_sh;
        r_q   <= n_q;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

@@ rtl/core/ema_history_bar_chart.sv @@
// EMA history bar chart: per sample, average update, ring write, max scan, bars.
// Per sample: accept, average/ring-write and check states, a scan over the filled
// entries plus a scan-end state, then per column a read, a divider start, the division
// and an output state that waits out any stall; fewer than two entries: no columns.
// A new sample is taken only after the last column of the previous pass is taken.
// Sync reset clears average, write pointer, full flag; height returns to 15.
module ema_history_bar_chart
    import ehbc_pkg::*;
#(
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration: chart_height
    input  logic                i_cfg_we,
    input  logic [HEIGHT_W-1:0] i_cfg_wdata,
    // sample requests
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [15:0]         s_axis_tdata,   // [15:0] rate_sample
    // bar results
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [15:0]         m_axis_tdata,   // [5:0] column, [11:6] bar_height, zero pad
    output logic                m_axis_tlast    // last_column
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int PROD_W = AVG_NUM_W + AVG_RECIP_W;
    localparam logic [AW:0]   DEPTH_L  = (AW+1)'(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(HISTORY_DEPTH - 1);

    t_state                r_state, n_state;
    logic [AVG_W-1:0]      r_avg, n_avg;
    logic [AVG_NUM_W-1:0]  r_avg_num, n_avg_num;
    logic [AW-1:0]         r_wp, n_wp;
    logic                  r_full, n_full;
    logic [HEIGHT_W-1:0]   r_h, n_h;
    logic [AVG_W-1:0]      r_max, n_max;
    logic [AW-1:0]         r_cnt, n_cnt;
    logic                  r_cmp_en, n_cmp_en;
    logic [COL_W-1:0]      r_col, n_col;
    logic [HEIGHT_W-1:0]   r_bar, n_bar;
    logic                  r_last, n_last;

    logic [AW:0]           fill_cnt;
    logic                  at_last;
    logic [AW:0]           idx_sum;
    logic [AW-1:0]         rd_idx;
    logic [AW+COL_W-1:0]   col_ext;
    logic [HEIGHT_W-1:0]   q_bar;
    logic [PROD_W-1:0]     avg_prod;
    logic [AVG_W-1:0]      avg_quot;

    logic                  div_start;
    logic [NUM_W-1:0]      div_num;
    logic [AVG_W-1:0]      div_den;
    logic                  div_done;
    logic [HEIGHT_W-1:0]   div_quot;

    logic                  ram_we;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [AVG_W-1:0]      ram_rdata;

    // History ring: written once per sample, read only in later cycles,
    // so no write/read overlap on one entry needs forwarding.
    ehbc_ram #(
        .WIDTH (AVG_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (avg_quot),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ehbc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Divide by 5 through the reciprocal
    assign avg_prod = {{AVG_RECIP_W{1'b0}}, r_avg_num} * {{AVG_NUM_W{1'b0}}, AVG_RECIP};
    assign avg_quot = avg_prod[AVG_SHIFT +: AVG_W];

    // Fill level and oldest-first read index
    assign fill_cnt = r_full ? DEPTH_L : {1'b0, r_wp};
    assign at_last  = ({1'b0, r_cnt} == (fill_cnt - (AW+1)'(1)));
    assign idx_sum  = (r_full ? {1'b0, r_wp} : '0) + {1'b0, r_cnt};
    assign rd_idx   = (idx_sum >= DEPTH_L) ? AW'(idx_sum - DEPTH_L) : idx_sum[AW-1:0];
    assign col_ext  = {{COL_W{1'b0}}, r_cnt};
    assign q_bar    = (div_quot > r_h) ? r_h : div_quot;

    // Sequencer: next state and datapath controls
    always_comb begin
        n_state   = r_state;
        n_avg     = r_avg;
        n_avg_num = r_avg_num;
        n_wp      = r_wp;
        n_full    = r_full;
        n_h       = i_cfg_we ? i_cfg_wdata : r_h;
        n_max     = r_max;
        n_cnt     = r_cnt;
        n_cmp_en  = (r_state == S_SCAN);
        n_col     = r_col;
        n_bar     = r_bar;
        n_last    = r_last;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = r_cnt;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;

        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    // 4*avg + 16*sample, divided by 5 in the next cycle
                    n_avg_num = AVG_NUM_W'({r_avg, 2'b00}) +
                                AVG_NUM_W'({s_axis_tdata, 4'b0000});
                    n_state   = S_AVG;
                end
            end
            S_AVG: begin
                n_avg  = avg_quot;
                ram_we = 1'b1;
                if (r_wp == LAST_IDX) begin
                    n_wp   = '0;
                    n_full = 1'b1;
                end else begin
                    n_wp = r_wp + AW'(1);
                end
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (fill_cnt < (AW+1)'(2)) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt   = '0;
                    n_max   = FLOOR_ONE;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                ram_re = 1'b1;
                if (r_cmp_en && (ram_rdata > r_max)) begin
                    n_max = ram_rdata;
                end
                if (at_last) begin
                    n_cnt   = '0;
                    n_state = S_SCAN_END;
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end
            S_SCAN_END: begin
                if (r_cmp_en && (ram_rdata > r_max)) begin
                    n_max = ram_rdata;
                end
                n_state = S_BAR_RD;
            end
            S_BAR_RD: begin
                ram_re    = 1'b1;
                ram_raddr = rd_idx;
                n_state   = S_BAR_START;
            end
            S_BAR_START: begin
                // value * height / max
                div_start = 1'b1;
                div_num   = NUM_W'(ram_rdata) * NUM_W'(r_h);
                div_den   = r_max;
                n_state   = S_BAR_DIV;
            end
            S_BAR_DIV: begin
                if (div_done) begin
                    n_col   = col_ext[COL_W-1:0];
                    n_bar   = q_bar;
                    n_last  = at_last;
                    n_state = S_BAR_OUT;
                end
            end
            S_BAR_OUT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) begin
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt   = r_cnt + AW'(1);
                        n_state = S_BAR_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_avg    <= '0;
            r_wp     <= '0;
            r_full   <= 1'b0;
            r_h      <= HEIGHT_RESET;
            r_cnt    <= '0;
            r_cmp_en <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_avg    <= n_avg;
            r_wp     <= n_wp;
            r_full   <= n_full;
            r_h      <= n_h;
            r_cnt    <= n_cnt;
            r_cmp_en <= n_cmp_en;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_avg_num <= n_avg_num;
        r_max     <= n_max;
        r_col     <= n_col;
        r_bar     <= n_bar;
        r_last    <= n_last;
    end

    assign m_axis_tdata = {4'b0000, r_bar, r_col};
    assign m_axis_tlast = r_last;

endmodule

@@ rtl/core/ehbc_checker.sv @@
// Port-level checker for the EMA history bar chart, bound to the top level.
// Depends on ehbc_pkg and on the top-level port list.
module ehbc_checker
    import ehbc_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_cfg_we,
    input logic [HEIGHT_W-1:0] i_cfg_wdata,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic [15:0]         s_axis_tdata,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [15:0]         m_axis_tdata,
    input logic                m_axis_tlast
);

    logic [COL_W-1:0]    r_exp_col;
    logic [HEIGHT_W-1:0] r_h;
    logic                out_acc;
    logic                in_acc;

    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign in_acc  = s_axis_tvalid && s_axis_tready;

    // Shadow of the expected column and of the height register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_col <= '0;
            r_h       <= HEIGHT_RESET;
        end else begin
            if (out_acc) begin
                r_exp_col <= m_axis_tlast ? '0 : r_exp_col + COL_W'(1);
            end
            if (i_cfg_we) begin
                r_h <= i_cfg_wdata;
            end
        end
    end

    // No sample request is taken while a bar waits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("sample ready while a bar is pending");

    // A taken sample keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !s_axis_tready)
        else $error("ready right after a sample was taken");

    // Columns run 0,1,2,... within a pass
    a_column_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> (m_axis_tdata[5:0] == r_exp_col))
        else $error("column out of sequence");

    // Bar never above the programmed height
    a_bar_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[11:6] <= r_h))
        else $error("bar height above chart height");

    // Stalled bar holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled bar changed");

endmodule

bind ema_history_bar_chart ehbc_checker u_ehbc_checker (.*);
